FILE: rtl/core/stlf_pkg.sv
package stlf_pkg;

  localparam int ADDR_W      = 32;
  localparam int TAG_W       = 16;
  localparam int TAG_LSB     = 16;
  localparam int SET_FIELD_W = 4;
  localparam int SET_LSB     = 12;
  localparam int SET_CODES   = 2 ** SET_FIELD_W;
  localparam int COUNT_W     = 32;

  localparam logic [COUNT_W-1:0] HIT_MAX = {COUNT_W{1'b1}};

  // One lookup request after the front has split the address.
  typedef struct packed {
    logic [TAG_W-1:0]       tag;
    logic [SET_FIELD_W-1:0] set_field;
  } req_t;

  // Head of the request queue as seen by the back part.
  typedef struct packed {
    logic valid;
    req_t item;
  } qhead_t;

endpackage

FILE: rtl/core/stlf_addr_if.sv
interface stlf_addr_if;
  logic                         valid;
  logic                         ready;
  logic [stlf_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

FILE: rtl/core/stlf_result_if.sv
interface stlf_result_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          filled;
  logic [stlf_pkg::COUNT_W-1:0]  hit_total;

  modport source (output valid, output hit, output filled, output hit_total, input ready);
  modport sink (input valid, input hit, input filled, input hit_total, output ready);
endinterface

FILE: rtl/core/stlf_ram.sv
module stlf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/stlf_front.sv
module stlf_front (
  input  logic                clk,
  input  logic                rst,
  stlf_addr_if.sink           req,
  output stlf_pkg::qhead_t    head,
  input  logic                pop
);

  localparam int QDEPTH = 2;

  stlf_pkg::req_t entries [QDEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  assign req.ready = (count != 2'(QDEPTH));
  assign push      = req.valid && req.ready;

  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Classification: tag and raw set field are pulled out on the way in.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr].tag <=
        req.address[stlf_pkg::TAG_LSB +: stlf_pkg::TAG_W];
      entries[wr_ptr].set_field <=
        req.address[stlf_pkg::SET_LSB +: stlf_pkg::SET_FIELD_W];
    end
  end

endmodule

FILE: rtl/core/stlf_back.sv
module stlf_back #(
  parameter int NUM_SETS = 16,
  parameter int NUM_WAYS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  stlf_pkg::qhead_t    head,
  output logic                pop,
  stlf_result_if.source       rsp
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int CNT_W = $clog2(NUM_WAYS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_CMP
  } state_t;

  state_t                          state;
  logic [stlf_pkg::TAG_W-1:0]      cur_tag;
  logic [SET_W-1:0]                cur_set;
  logic [CNT_W-1:0]                fill_cnt [NUM_SETS];
  logic [stlf_pkg::COUNT_W-1:0]    hit_count;
  logic [stlf_pkg::COUNT_W-1:0]    hit_count_next;

  logic [SET_W-1:0]                set_lut [stlf_pkg::SET_CODES];
  logic [SET_W-1:0]                head_set;
  logic [SET_W-1:0]                rd_set;
  logic [stlf_pkg::TAG_W-1:0]      way_tag [NUM_WAYS];
  logic [NUM_WAYS-1:0]             match;
  logic [NUM_WAYS-1:0]             way_we;
  logic [CNT_W-1:0]                cnt;
  logic                            hit;
  logic                            finish;
  logic                            do_fill;

  // Set field wraps modulo the set count through a constant table.
  for (genvar i = 0; i < stlf_pkg::SET_CODES; i++) begin : g_lut
    assign set_lut[i] = SET_W'(i % NUM_SETS);
  end

  assign head_set = set_lut[head.item.set_field];
  assign rd_set   = (state == ST_IDLE) ? head_set : cur_set;

  // Ways fill strictly in order and are never freed, so the ways below the
  // fill count of a set are exactly its valid ways.
  assign cnt = fill_cnt[cur_set];

  for (genvar w = 0; w < NUM_WAYS; w++) begin : g_way
    stlf_ram #(
      .WIDTH (stlf_pkg::TAG_W),
      .DEPTH (NUM_SETS)
    ) u_tag_ram (
      .clk   (clk),
      .we    (way_we[w]),
      .waddr (cur_set),
      .wdata (cur_tag),
      .raddr (rd_set),
      .rdata (way_tag[w])
    );
    assign match[w]  = (CNT_W'(w) < cnt) && (way_tag[w] == cur_tag);
    assign way_we[w] = do_fill && (cnt == CNT_W'(w));
  end

  assign hit     = |match;
  assign finish  = (state == ST_CMP) && (!rsp.valid || rsp.ready);
  assign do_fill = finish && !hit && (cnt != CNT_W'(NUM_WAYS));
  assign pop     = (state == ST_IDLE) && head.valid;

  assign hit_count_next = (hit && hit_count != stlf_pkg::HIT_MAX) ?
                          hit_count + 1'b1 : hit_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
      hit_count <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        fill_cnt[s] <= '0;
      end
    end else begin
      if (finish) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            cur_tag <= head.item.tag;
            cur_set <= head_set;
            state   <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (finish) begin
            rsp.hit       <= hit;
            rsp.filled    <= do_fill;
            rsp.hit_total <= hit_count_next;
            hit_count     <= hit_count_next;
            if (do_fill) begin
              fill_cnt[cur_set] <= cnt + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/set_assoc_tag_lookup_fill.sv
// An address is written into a two-entry queue; the lookup side pops it into its
// current tag and set registers as the tag RAM read is registered, and the compare
// result is then registered on the result port. A new address is popped only after
// the compare and fill write of the same set, which wait for room on the result port.
// Reset (synchronous, rst high) empties the queue, marks every way invalid
// through the per-set fill counts and clears the hit count; tag RAMs are not swept.
module set_assoc_tag_lookup_fill #(
  parameter int NUM_SETS = 16,
  parameter int NUM_WAYS = 8
) (
  input  logic           clk,
  input  logic           rst,
  stlf_addr_if.sink      req,
  stlf_result_if.source  rsp
);

  stlf_pkg::qhead_t qhead;
  logic             pop;

  stlf_front u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (qhead),
    .pop  (pop)
  );

  stlf_back #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (qhead),
    .pop  (pop),
    .rsp  (rsp)
  );

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> qhead.valid)
    else $error("queue popped while empty");

  a_hit_xor_fill: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.filled))
    else $error("result reports both hit and fill");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.hit) |-> (rsp.hit_total != '0))
    else $error("hit reported with zero hit total");

endmodule

FILE: tb/set_assoc_tag_lookup_fill_test.sv
`timescale 1ns / 100ps

module set_assoc_tag_lookup_fill_test;

  localparam int NUM_SETS   = 16;
  localparam int NUM_WAYS   = 8;
  localparam int POOL_TAGS  = 12;
  localparam int RAND_ITEMS = 2000;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 10;

  typedef struct packed {
    logic                        drain_first;
    logic [stlf_pkg::ADDR_W-1:0] address;
  } pending_addr_t;

  typedef struct packed {
    logic                         hit;
    logic                         filled;
    logic [stlf_pkg::COUNT_W-1:0] hit_total;
  } lookup_result_t;

  logic clk;
  logic rst;

  stlf_addr_if   req ();
  stlf_result_if rsp ();

  set_assoc_tag_lookup_fill #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Shadow copy of the tag array, valid bits and hit count.
  logic [stlf_pkg::TAG_W-1:0]   shadow_tags  [NUM_SETS][NUM_WAYS];
  logic                         shadow_valid [NUM_SETS][NUM_WAYS];
  logic [stlf_pkg::COUNT_W-1:0] shadow_hits;

  logic [stlf_pkg::TAG_W-1:0] tag_pool [NUM_SETS][POOL_TAGS];

  pending_addr_t  addr_q[$];
  lookup_result_t expect_q[$];

  pending_addr_t drv_item;
  lookup_result_t want;
  int addr_total;
  int addrs_taken;
  int mismatches;
  int idle_cycles;
  int send_wait;
  int send_count;
  bit send_calm;
  int recv_wait;
  int recv_count;
  bit recv_calm;

  function automatic lookup_result_t lookup_and_fill(
    input logic [stlf_pkg::ADDR_W-1:0] address
  );
    logic [stlf_pkg::TAG_W-1:0] tag;
    int set_idx;
    int free_way;
    int w;
    lookup_result_t res;
    tag = address[stlf_pkg::TAG_LSB +: stlf_pkg::TAG_W];
    set_idx = int'(address[stlf_pkg::SET_LSB +: stlf_pkg::SET_FIELD_W]) % NUM_SETS;
    free_way = -1;
    res = '0;
    for (w = 0; w < NUM_WAYS; w++) begin
      if (shadow_valid[set_idx][w]) begin
        if (shadow_tags[set_idx][w] == tag) res.hit = 1'b1;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (res.hit) begin
      if (shadow_hits != stlf_pkg::HIT_MAX) shadow_hits = shadow_hits + 1'b1;
    end else if (free_way >= 0) begin
      shadow_tags[set_idx][free_way] = tag;
      shadow_valid[set_idx][free_way] = 1'b1;
      res.filled = 1'b1;
    end
    res.hit_total = shadow_hits;
    return res;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic queue_addr(input logic [stlf_pkg::ADDR_W-1:0] address,
                            input bit drain_first);
    pending_addr_t p;
    p.address = address;
    p.drain_first = drain_first;
    addr_q.push_back(p);
  endtask

  always #5 clk = ~clk;

  // Address driver: holds each transfer until accepted, then idles for the drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.address <= '0;
      send_wait = 0;
    end else if (!req.valid || req.ready) begin
      if (send_wait != 0) begin
        send_wait--;
        req.valid <= 1'b0;
      end else if (addr_q.size() != 0 &&
                   !(addr_q[0].drain_first && (req.valid || expect_q.size() != 0))) begin
        drv_item = addr_q.pop_front();
        req.valid <= 1'b1;
        req.address <= drv_item.address;
        send_count++;
        if (send_count % 100 == 0) send_calm = ($urandom_range(0, 2) == 0);
        send_wait = send_calm ? 0 : $urandom_range(0, 3);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Result sink: after each transfer, drops ready for the drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_wait = 0;
    end else if (rsp.valid && rsp.ready) begin
      recv_count++;
      if (recv_count % 100 == 0) recv_calm = ($urandom_range(0, 2) == 0);
      recv_wait = recv_calm ? 0 : $urandom_range(0, 3);
      rsp.ready <= (recv_wait == 0);
    end else if (recv_wait != 0) begin
      recv_wait--;
      rsp.ready <= (recv_wait == 0);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Monitor: predicts on every address transfer and checks every result transfer.
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (req.valid && req.ready) begin
        expect_q.push_back(lookup_and_fill(req.address));
        addrs_taken++;
        idle_cycles = 0;
      end
      if (rsp.valid && rsp.ready) begin
        idle_cycles = 0;
        if (expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result: hit=%0b filled=%0b hit_total=%0d",
                                  rsp.hit, rsp.filled, rsp.hit_total));
        end else begin
          want = expect_q.pop_front();
          if (rsp.hit !== want.hit)
            note_mismatch($sformatf("hit: expected %0b, got %0b", want.hit, rsp.hit));
          if (rsp.filled !== want.filled)
            note_mismatch($sformatf("filled: expected %0b, got %0b", want.filled, rsp.filled));
          if (rsp.hit_total !== want.hit_total)
            note_mismatch($sformatf("hit_total: expected %0d, got %0d",
                                    want.hit_total, rsp.hit_total));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("set_assoc_tag_lookup_fill regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int s;
    int k;
    int i;
    logic [stlf_pkg::TAG_W-1:0] tag;
    logic [3:0] set_code;

    clk = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.address = '0;
    rsp.ready = 1'b0;
    shadow_hits = '0;
    mismatches = 0;
    addrs_taken = 0;
    idle_cycles = 0;
    send_count = 0;
    send_calm = 1'b0;
    recv_count = 0;
    recv_calm = 1'b0;
    for (s = 0; s < NUM_SETS; s++) begin
      for (k = 0; k < NUM_WAYS; k++) begin
        shadow_tags[s][k] = '0;
        shadow_valid[s][k] = 1'b0;
      end
      for (k = 0; k < POOL_TAGS; k++) tag_pool[s][k] = 16'($urandom_range(0, 16'hFFFF));
    end

    // Tags zero and all-ones each fill, then hit, then fill again in the other's set.
    queue_addr(32'h0000_0000, 1'b0);
    queue_addr(32'h0000_0FFF, 1'b0);
    queue_addr(32'hFFFF_FFFF, 1'b0);
    queue_addr(32'hFFFF_F000, 1'b0);
    queue_addr(32'h0000_F000, 1'b0);
    queue_addr(32'hFFFF_0000, 1'b0);
    // Fill every way of one set, miss on the full set, then hit first and last way.
    for (k = 0; k < NUM_WAYS; k++) queue_addr({16'h1000 + 16'(k), 4'h5, 12'hABC}, 1'b0);
    queue_addr({16'h2000, 4'h5, 12'h123}, 1'b0);
    queue_addr({16'h1000 + 16'(NUM_WAYS - 1), 4'h5, 12'h000}, 1'b0);
    queue_addr({16'h1000, 4'h5, 12'hFFF}, 1'b0);
    queue_addr(32'hAAAA_A555, 1'b0);
    queue_addr(32'h5555_5AAA, 1'b0);

    // Mostly tags from a small per-set pool, so sets fill, hit and overflow.
    for (i = 0; i < RAND_ITEMS; i++) begin
      set_code = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 8)
        tag = tag_pool[set_code % NUM_SETS][$urandom_range(0, POOL_TAGS - 1)];
      else
        tag = 16'($urandom);
      queue_addr({tag, set_code, 12'($urandom)}, (i == 0) || (i == RAND_ITEMS / 2));
    end
    addr_total = addr_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (addrs_taken != addr_total || expect_q.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("set_assoc_tag_lookup_fill regression: pass");
    end else begin
      $display("set_assoc_tag_lookup_fill regression: fail");
    end
    $finish;
  end

endmodule
